// ===== rtl/ssic_pkg.sv =====
// ----------------------------------------------------------------------------
// ssic_pkg
// Shared types, sizes and the coefficient table of the state-space controller.
// ----------------------------------------------------------------------------
package ssic_pkg;

	// Matrix sizes; the coefficient table is built for exactly these.
	localparam int NUM_STATES = 5;
	localparam int NUM_AXES   = 3;
	localparam int NUM_WHEELS = 4;
	localparam int NUM_LANES  = (NUM_STATES > NUM_WHEELS) ? NUM_STATES : NUM_WHEELS;
	localparam int NUM_COLS   = NUM_STATES + NUM_AXES;
	localparam int COL_W      = $clog2(NUM_COLS + 1);

	localparam int OFF_A     = 0;
	localparam int OFF_B     = OFF_A + NUM_STATES * NUM_STATES;
	localparam int OFF_C     = OFF_B + NUM_STATES * NUM_AXES;
	localparam int OFF_D     = OFF_C + NUM_WHEELS * NUM_STATES;
	localparam int ROM_DEPTH = OFF_D + NUM_WHEELS * NUM_AXES;
	localparam int ROM_IDX_W = $clog2(ROM_DEPTH);

	localparam int VEL_W   = 16;
	localparam int DT_W    = 16;
	localparam int COEF_W  = 24;
	localparam int WORD_W  = 32;
	localparam int ACC_W   = 64;
	localparam int SPEED_W = 16;
	localparam int LIMIT_W = 15;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd25600;

	typedef logic signed [VEL_W-1:0]   vel_t;
	typedef logic        [DT_W-1:0]    dt_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [WORD_W-1:0]  word_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic        [LIMIT_W-1:0] limit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INTEG,
		ST_XMAC,
		ST_XWB,
		ST_YMAC,
		ST_YWB
	} state_t;

	// Per-lane control: clear the accumulator, issue a product, scale it by 16.
	typedef struct packed {
		logic clear;
		logic issue;
		logic scale;
	} lane_ctrl_t;

	// A (5x5), B (5x3), C (4x5), D (4x3), row-major, signed Q10.14.
	localparam coef_t COEF_ROM [ROM_DEPTH] = '{
		-24'sd5105, 24'sd2698, -24'sd26, -24'sd8, 24'sd0,
		24'sd2309, -24'sd1751, -24'sd146, -24'sd44, 24'sd0,
		-24'sd16, -24'sd106, -24'sd6465, 24'sd3039, 24'sd16,
		24'sd2, 24'sd10, -24'sd896, 24'sd493, 24'sd93,
		24'sd0, 24'sd0, -24'sd2, 24'sd20, -24'sd580,
		-24'sd29950, -24'sd41458, 24'sd20439,
		-24'sd4529, 24'sd22941, -24'sd10474,
		24'sd21055, 24'sd11043, -24'sd5005,
		24'sd22920, -24'sd572, -24'sd872,
		24'sd19893, -24'sd2363, -24'sd106,
		24'sd100583, -24'sd116634, 24'sd762246, -24'sd629693, 24'sd105991,
		24'sd607574, 24'sd1256536, -24'sd49252, -24'sd734847, 24'sd2195697,
		-24'sd2256848, -24'sd4161634, 24'sd18101, -24'sd3283952, -24'sd484087,
		24'sd2942871, 24'sd5261586, 24'sd723082, 24'sd1689900, 24'sd2977705,
		24'sd218453, 24'sd138627, 24'sd4786,
		24'sd158830, -24'sd141166, 24'sd3854,
		24'sd185264, 24'sd172992, -24'sd50296,
		24'sd203984, -24'sd174906, 24'sd57755
	};

	// Table read; addresses past the end read as zero.
	function automatic coef_t coef_at(input logic [ROM_IDX_W-1:0] idx);
		coef_t c;
		c = '0;
		if (int'(idx) < ROM_DEPTH) begin
			c = COEF_ROM[idx];
		end
		return c;
	endfunction

endpackage

// ===== rtl/ssic_if.sv =====
// ----------------------------------------------------------------------------
// ssic_in_if / ssic_out_if
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface ssic_in_if import ssic_pkg::*; ();
	logic valid;
	logic ready;
	vel_t command_vx;
	vel_t command_vy;
	vel_t command_wz;
	vel_t measured_vx;
	vel_t measured_vy;
	vel_t measured_wz;
	dt_t  elapsed;

	modport source (output valid, command_vx, command_vy, command_wz,
		measured_vx, measured_vy, measured_wz, elapsed, input ready);
	modport sink (input valid, command_vx, command_vy, command_wz,
		measured_vx, measured_vy, measured_wz, elapsed, output ready);
endinterface

interface ssic_out_if import ssic_pkg::*; ();
	logic       valid;
	logic       ready;
	speed_t     left_front_speed;
	speed_t     right_front_speed;
	speed_t     right_back_speed;
	speed_t     left_back_speed;
	logic [3:0] clamped_mask;

	modport source (output valid, left_front_speed, right_front_speed,
		right_back_speed, left_back_speed, clamped_mask, input ready);
	modport sink (input valid, left_front_speed, right_front_speed,
		right_back_speed, left_back_speed, clamped_mask, output ready);
endinterface

// ===== rtl/state_space_integral_controller_core.sv =====
// ----------------------------------------------------------------------------
// state_space_integral_controller_core
// State-space wheel-speed controller with integral action.
// ----------------------------------------------------------------------------
// One item is one control tick and gives one result item. After acceptance,
// a tick runs the integrators, then two passes of the five MAC lanes over the
// eight matrix columns (state update, then wheel speeds), each pass followed
// by a write-back state. The last write-back waits while the output register
// still holds a result that has not been taken. A new item is taken only when
// the block is idle, but a finished result may wait in the output register
// while the next tick is being worked on.
module state_space_integral_controller_core import ssic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ssic_in_if.sink     in_ch,
	ssic_out_if.source  out_ch,
	input  logic        cfg_wr_en,
	input  limit_t      cfg_wr_data
);

	state_t state_q, state_nxt;
	logic [COL_W-1:0] step_q;
	limit_t limit_q;

	vel_t  cmd_q [3];
	vel_t  meas_q [3];
	dt_t   dt_q;
	word_t integ_q [NUM_AXES];
	word_t integ_nxt [NUM_AXES];
	word_t xst_q [NUM_STATES];
	word_t xst_nxt [NUM_STATES];

	lane_ctrl_t lane_ctrl;
	logic       phase_y;
	coef_t      lane_coef [NUM_LANES];
	word_t      lane_op;
	acc_t       lane_acc [NUM_LANES];

	speed_t     speed [NUM_WHEELS];
	logic [3:0] mask;
	logic       out_vld_q;
	logic       in_acc;
	logic       out_free;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid & in_ch.ready;
	assign out_free    = ~out_vld_q | out_ch.ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc) state_nxt = ST_INTEG;
			ST_INTEG: state_nxt = ST_XMAC;
			ST_XMAC:  if (int'(step_q) == NUM_COLS) state_nxt = ST_XWB;
			ST_XWB:   state_nxt = ST_YMAC;
			ST_YMAC:  if (int'(step_q) == NUM_COLS) state_nxt = ST_YWB;
			ST_YWB:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Lane control outputs.
	always_comb begin
		lane_ctrl = '0;
		phase_y   = 1'b0;
		unique case (state_q) inside
			ST_INTEG, ST_XWB: begin
				lane_ctrl.clear = 1'b1;
			end
			ST_XMAC: begin
				lane_ctrl.issue = (int'(step_q) < NUM_COLS);
				lane_ctrl.scale = (int'(step_q) < NUM_STATES);
			end
			ST_YMAC: begin
				phase_y         = 1'b1;
				lane_ctrl.issue = (int'(step_q) < NUM_COLS);
				lane_ctrl.scale = (int'(step_q) < NUM_STATES);
			end
			default: begin
				lane_ctrl = '0;
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_XMAC || state_q == ST_YMAC) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Input item capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q[0]  <= in_ch.command_vx;
			cmd_q[1]  <= in_ch.command_vy;
			cmd_q[2]  <= in_ch.command_wz;
			meas_q[0] <= in_ch.measured_vx;
			meas_q[1] <= in_ch.measured_vy;
			meas_q[2] <= in_ch.measured_wz;
			dt_q      <= in_ch.elapsed;
		end
	end

	ssic_integ u_integ (
		.command   (cmd_q),
		.measured  (meas_q),
		.elapsed   (dt_q),
		.integ_cur (integ_q),
		.integ_nxt (integ_nxt)
	);

	// Integrators and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_AXES; k++) integ_q[k] <= '0;
			for (int k = 0; k < NUM_STATES; k++) xst_q[k] <= '0;
		end else begin
			if (state_q == ST_INTEG) begin
				integ_q <= integ_nxt;
			end
			if (state_q == ST_XWB) begin
				xst_q <= xst_nxt;
			end
		end
	end

	// Column operand shared by all lanes: state words, then integrators.
	always_comb begin
		lane_op = '0;
		for (int j = 0; j < NUM_STATES; j++) begin
			if (int'(step_q) == j) begin
				lane_op = xst_q[j];
			end
		end
		for (int j = 0; j < NUM_AXES; j++) begin
			if (int'(step_q) == NUM_STATES + j) begin
				lane_op = integ_q[j];
			end
		end
	end

	// Coefficient of each lane's row at the current column.
	always_comb begin
		int idx;
		int col;
		for (int r = 0; r < NUM_LANES; r++) begin
			col = int'(step_q);
			if (col >= NUM_COLS) col = 0;
			if (phase_y) begin
				idx = (col < NUM_STATES) ? OFF_C + r * NUM_STATES + col
					: OFF_D + r * NUM_AXES + col - NUM_STATES;
			end else begin
				idx = (col < NUM_STATES) ? OFF_A + r * NUM_STATES + col
					: OFF_B + r * NUM_AXES + col - NUM_STATES;
			end
			if ((phase_y && r >= NUM_WHEELS) || (!phase_y && r >= NUM_STATES)) begin
				lane_coef[r] = '0;
			end else begin
				lane_coef[r] = coef_at(ROM_IDX_W'(idx));
			end
		end
	end

	for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
		ssic_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (lane_ctrl),
			.coef    (lane_coef[r]),
			.operand (lane_op),
			.acc     (lane_acc[r])
		);
	end

	ssic_merge u_merge (
		.acc       (lane_acc),
		.limit     (limit_q),
		.state_nxt (xst_nxt),
		.speed     (speed),
		.mask      (mask)
	);

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_YWB && out_free) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_YWB && out_free) begin
			out_ch.left_front_speed  <= speed[0];
			out_ch.right_front_speed <= speed[1];
			out_ch.right_back_speed  <= speed[2];
			out_ch.left_back_speed   <= speed[3];
			out_ch.clamped_mask      <= mask;
		end
	end

	assign out_ch.valid = out_vld_q;

endmodule

// ===== rtl/ssic_integ.sv =====
// ----------------------------------------------------------------------------
// ssic_integ
// Velocity error times elapsed time, rounded and added to the integrators.
// ----------------------------------------------------------------------------
module ssic_integ import ssic_pkg::*; (
	input  vel_t  command [3],
	input  vel_t  measured [3],
	input  dt_t   elapsed,
	input  word_t integ_cur [NUM_AXES],
	output word_t integ_nxt [NUM_AXES]
);

	localparam logic signed [33:0] INC_HALF = 34'sd8;

	// Each axis is independent: exact error, Q.28 product, round to Q.24, saturate.
	always_comb begin
		logic signed [16:0] err;
		logic signed [33:0] prod;
		logic signed [33:0] inc;
		logic signed [34:0] sum;
		for (int k = 0; k < NUM_AXES; k++) begin
			err  = 17'(command[k]) - 17'(measured[k]);
			prod = 34'(err) * $signed({18'd0, elapsed});
			inc  = (prod + INC_HALF) >>> 4;
			sum  = 35'(integ_cur[k]) + 35'(inc);
			if (sum > 35'sh0_7FFF_FFFF) begin
				integ_nxt[k] = 32'sh7FFF_FFFF;
			end else if (sum < -35'sh0_8000_0000) begin
				integ_nxt[k] = -32'sh8000_0000;
			end else begin
				integ_nxt[k] = sum[31:0];
			end
		end
	end

endmodule

// ===== rtl/ssic_lane.sv =====
// ----------------------------------------------------------------------------
// ssic_lane
// One multiply-accumulate lane; it works through one matrix row.
// ----------------------------------------------------------------------------
module ssic_lane import ssic_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  coef_t      coef,
	input  word_t      operand,
	output acc_t       acc
);

	logic signed [COEF_W+WORD_W-1:0] prod;
	acc_t prod_s1;
	logic prod_vld_s1;
	acc_t acc_q;

	assign prod = coef * operand;

	// Product valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctrl.issue & ~ctrl.clear;
		end
	end

	// Registered product, state terms brought to the same scale as the others.
	always_ff @(posedge clk) begin
		if (ctrl.scale) begin
			prod_s1 <= ACC_W'(prod) <<< 4;
		end else begin
			prod_s1 <= ACC_W'(prod);
		end
	end

	// Exact accumulation of the row.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + prod_s1;
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/ssic_merge.sv =====
// ----------------------------------------------------------------------------
// ssic_merge
// Rounds lane sums into the new state and into clamped wheel speeds.
// ----------------------------------------------------------------------------
module ssic_merge import ssic_pkg::*; (
	input  acc_t       acc [NUM_LANES],
	input  limit_t     limit,
	output word_t      state_nxt [NUM_STATES],
	output speed_t     speed [NUM_WHEELS],
	output logic [3:0] mask
);

	localparam acc_t STATE_HALF = acc_t'(64'sd1 <<< 17);
	localparam acc_t SPEED_HALF = acc_t'(64'sd1 <<< 29);

	// State: round Q.38 to Q.20 and saturate to 32 bits.
	always_comb begin
		acc_t t;
		for (int r = 0; r < NUM_STATES; r++) begin
			t = (acc[r] + STATE_HALF) >>> 18;
			if (t > 64'sh0000_0000_7FFF_FFFF) begin
				state_nxt[r] = 32'sh7FFF_FFFF;
			end else if (t < -64'sh0000_0000_8000_0000) begin
				state_nxt[r] = -32'sh8000_0000;
			end else begin
				state_nxt[r] = t[31:0];
			end
		end
	end

	// Speeds: round Q.38 to Q.8 and clamp to the symmetric limit.
	always_comb begin
		logic signed [33:0] y;
		logic signed [33:0] lim;
		lim = $signed({19'd0, limit});
		for (int r = 0; r < NUM_WHEELS; r++) begin
			y = 34'((acc[r] + SPEED_HALF) >>> 30);
			mask[r] = 1'b0;
			if (y > lim) begin
				y = lim;
				mask[r] = 1'b1;
			end else if (y < -lim) begin
				y = -lim;
				mask[r] = 1'b1;
			end
			speed[r] = y[15:0];
		end
	end

endmodule
